/* rtl/ale_pkg.sv */
package ale_pkg;

    localparam int DEPTH = 32;
    localparam int WIDTH = 32;
    localparam int CW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [CW-1:0]    t_slot;
    typedef logic [NW-1:0]    t_count;

    // what a cell loads at the next edge
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_HOLD  = 2'd0;
    localparam t_sel SEL_LOAD  = 2'd1;
    localparam t_sel SEL_LEFT  = 2'd2;
    localparam t_sel SEL_RIGHT = 2'd3;

    typedef logic [2:0] t_op;
    localparam t_op OP_APPEND     = 3'd0;
    localparam t_op OP_INSERT     = 3'd1;
    localparam t_op OP_REMOVE     = 3'd2;
    localparam t_op OP_FIND_FIRST = 3'd3;
    localparam t_op OP_FIND_LAST  = 3'd4;
    localparam t_op OP_SORT       = 3'd5;
    localparam t_op OP_DUMP_FWD   = 3'd6;
    localparam t_op OP_DUMP_BWD   = 3'd7;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_BADPOS   = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

endpackage

/* rtl/array_list_engine_unit.sv */
// Ordered list of up to DEPTH words held in a row of cells, one entry per
// cell. Issue a command with start while busy is low; it is taken at that
// edge. Append, insert and remove finish in the execute state alone, so busy
// is high for one cycle and the next command can then be issued. Find, sort
// and dump on a non-empty list go on from there to rotate or exchange the
// whole row once in the scan state, and busy stays high until that ends.
// Any command on an empty list also ends in the execute state. Every result
// beat is shown for exactly one cycle with o_valid high and cannot be held
// off: sample it when it comes. A dump gives one beat per entry, one per
// cycle, with o_last on the final one; every other command gives one beat.
module array_list_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [4:0]  o_index,
    output logic [31:0] o_data_out,
    output logic [5:0]  o_length,
    output logic        o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]       r_state, n_state;
    ale_pkg::t_slot   r_step, n_step;
    ale_pkg::t_count  r_count, n_count;
    logic             r_hit, n_hit;
    ale_pkg::t_slot   r_idx, n_idx;
    ale_pkg::t_op     r_op;
    logic [4:0]       r_pos;
    ale_pkg::t_word   r_val;

    logic             r_valid, n_valid;
    ale_pkg::t_status r_status, n_status;
    logic [4:0]       r_index, n_index;
    logic [31:0]      r_data, n_data;
    logic [5:0]       r_length;
    logic             r_last, n_last;

    ale_pkg::t_word   cell_word [ale_pkg::DEPTH];
    ale_pkg::t_sel    cell_sel  [ale_pkg::DEPTH];
    logic [ale_pkg::DEPTH-1:0] cell_gt;

    ale_pkg::t_word   head, tail;
    ale_pkg::t_count  pos_ext;
    logic             full, ins_ok, rem_ok, in_list, last_step, back_in, hit_now;

    assign head      = cell_word[0];
    assign tail      = cell_word[ale_pkg::DEPTH-1];
    assign pos_ext   = ale_pkg::NW'(r_pos);
    assign full      = r_count >= ale_pkg::NW'(ale_pkg::DEPTH);
    assign ins_ok    = !full && (pos_ext <= r_count);
    assign rem_ok    = (r_count != '0) && (pos_ext < r_count);
    assign in_list   = ale_pkg::NW'(r_step) < r_count;
    assign last_step = r_step == ale_pkg::CW'(ale_pkg::DEPTH - 1);
    assign back_in   = ((ale_pkg::NW + 1)'(r_step) + (ale_pkg::NW + 1)'(r_count))
                       >= (ale_pkg::NW + 1)'(ale_pkg::DEPTH);
    assign hit_now   = in_list && (head == r_val);

    // row of cells, closed into a ring for rotation
    for (genvar i = 0; i < ale_pkg::DEPTH; i++) begin : g_cell
        ale_cell u_cell (
            .i_clk        (i_clk),
            .i_sel        (cell_sel[i]),
            .i_load_word  (r_val),
            .i_left_word  (cell_word[(i + ale_pkg::DEPTH - 1) % ale_pkg::DEPTH]),
            .i_right_word (cell_word[(i + 1) % ale_pkg::DEPTH]),
            .o_word       (cell_word[i]),
            .o_gt         (cell_gt[i])
        );

        always_comb begin
            cell_sel[i] = ale_pkg::SEL_HOLD;
            if (r_state == S_EXEC) begin
                unique case (r_op)
                    ale_pkg::OP_APPEND: begin
                        if (!full && r_count == ale_pkg::NW'(i))
                            cell_sel[i] = ale_pkg::SEL_LOAD;
                    end
                    ale_pkg::OP_INSERT: begin
                        if (ins_ok && pos_ext == ale_pkg::NW'(i))
                            cell_sel[i] = ale_pkg::SEL_LOAD;
                        else if (ins_ok && ale_pkg::NW'(i) > pos_ext
                                 && ale_pkg::NW'(i) <= r_count)
                            cell_sel[i] = ale_pkg::SEL_LEFT;
                    end
                    ale_pkg::OP_REMOVE: begin
                        // close up the tail behind the removed entry
                        if (rem_ok && ale_pkg::NW'(i) >= pos_ext
                            && ale_pkg::NW'(i + 1) < r_count)
                            cell_sel[i] = ale_pkg::SEL_RIGHT;
                    end
                    default: cell_sel[i] = ale_pkg::SEL_HOLD;
                endcase
            end else if (r_state == S_SCAN) begin
                unique case (r_op)
                    ale_pkg::OP_FIND_FIRST,
                    ale_pkg::OP_FIND_LAST,
                    ale_pkg::OP_DUMP_FWD: cell_sel[i] = ale_pkg::SEL_RIGHT;
                    ale_pkg::OP_DUMP_BWD: cell_sel[i] = ale_pkg::SEL_LEFT;
                    ale_pkg::OP_SORT: begin
                        // odd-even transposition: pair parity follows the step
                        if (r_step[0] == 1'(i % 2)) begin
                            if (ale_pkg::NW'(i + 1) < r_count && cell_gt[i])
                                cell_sel[i] = ale_pkg::SEL_RIGHT;
                        end else begin
                            if (i != 0 && ale_pkg::NW'(i) < r_count
                                && cell_gt[(i + ale_pkg::DEPTH - 1) % ale_pkg::DEPTH])
                                cell_sel[i] = ale_pkg::SEL_LEFT;
                        end
                    end
                    default: cell_sel[i] = ale_pkg::SEL_HOLD;
                endcase
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_count  = r_count;
        n_hit    = r_hit;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_status = ale_pkg::ST_OK;
        n_index  = '0;
        n_data   = '0;
        n_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (start)
                    n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_step  = '0;
                n_hit   = 1'b0;
                n_idx   = '0;
                unique case (r_op)
                    ale_pkg::OP_APPEND: begin
                        n_valid = 1'b1;
                        if (full)
                            n_status = ale_pkg::ST_FULL;
                        else
                            n_count = r_count + 1'b1;
                    end
                    ale_pkg::OP_INSERT: begin
                        n_valid = 1'b1;
                        if (full)
                            n_status = ale_pkg::ST_FULL;
                        else if (!ins_ok)
                            n_status = ale_pkg::ST_BADPOS;
                        else
                            n_count = r_count + 1'b1;
                    end
                    ale_pkg::OP_REMOVE: begin
                        n_valid = 1'b1;
                        if (r_count == '0)
                            n_status = ale_pkg::ST_EMPTY;
                        else if (!rem_ok)
                            n_status = ale_pkg::ST_BADPOS;
                        else
                            n_count = r_count - 1'b1;
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            if (r_op == ale_pkg::OP_FIND_FIRST
                                || r_op == ale_pkg::OP_FIND_LAST)
                                n_status = ale_pkg::ST_NOTFOUND;
                            else if (r_op == ale_pkg::OP_SORT)
                                n_status = ale_pkg::ST_OK;
                            else
                                n_status = ale_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                n_step = r_step + 1'b1;
                unique case (r_op)
                    ale_pkg::OP_FIND_FIRST,
                    ale_pkg::OP_FIND_LAST: begin
                        if (hit_now && (r_op == ale_pkg::OP_FIND_LAST || !r_hit)) begin
                            n_hit = 1'b1;
                            n_idx = r_step;
                        end
                        if (last_step) begin
                            n_valid  = 1'b1;
                            n_status = n_hit ? ale_pkg::ST_OK : ale_pkg::ST_NOTFOUND;
                            n_index  = 5'(n_idx);
                        end
                    end
                    ale_pkg::OP_SORT: begin
                        n_valid = last_step;
                    end
                    ale_pkg::OP_DUMP_FWD: begin
                        if (in_list) begin
                            n_valid = 1'b1;
                            n_index = 5'(r_step);
                            n_data  = 32'(head);
                            n_last  = (ale_pkg::NW'(r_step) + 1'b1) == r_count;
                        end
                    end
                    ale_pkg::OP_DUMP_BWD: begin
                        // entries pass the far end highest index first
                        if (back_in) begin
                            n_valid = 1'b1;
                            n_index = 5'(ale_pkg::CW'(ale_pkg::DEPTH - 1) - r_step);
                            n_data  = 32'(tail);
                            n_last  = last_step;
                        end
                    end
                    default: n_valid = 1'b0;
                endcase
                if (last_step)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_hit    <= n_hit;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_index  <= n_index;
        r_data   <= n_data;
        r_length <= 6'(n_count);
        r_last   <= n_last;
        if (r_state == S_IDLE && start) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= ale_pkg::WIDTH'(i_value);
        end
    end

    assign busy       = r_state != S_IDLE;
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_index    = r_index;
    assign o_data_out = r_data;
    assign o_length   = r_length;
    assign o_last     = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ale_pkg::NW'(ale_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SCAN) |=> $stable(r_count))
        else $error("entry count moved outside the execute cycle");

    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ale_pkg::ST_OK))
        else $error("intermediate beat with an error status");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("intermediate beat with the engine idle");

endmodule

/* rtl/ale_cell.sv */
module ale_cell (
    input  logic          i_clk,
    input  ale_pkg::t_sel  i_sel,
    input  ale_pkg::t_word i_load_word,
    input  ale_pkg::t_word i_left_word,
    input  ale_pkg::t_word i_right_word,
    output ale_pkg::t_word o_word,
    output logic          o_gt
);

    ale_pkg::t_word r_word;
    ale_pkg::t_word n_word;

    always_comb begin
        unique case (i_sel)
            ale_pkg::SEL_HOLD:  n_word = r_word;
            ale_pkg::SEL_LOAD:  n_word = i_load_word;
            ale_pkg::SEL_LEFT:  n_word = i_left_word;
            ale_pkg::SEL_RIGHT: n_word = i_right_word;
            default:            n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    // compare against the right-hand neighbour for the sort exchange
    assign o_gt   = r_word > i_right_word;

endmodule

/* verif/tb_array_list_engine_unit.sv */
module tb_array_list_engine_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [4:0]  i_position;
    logic [31:0] i_value;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [4:0]  o_index;
    logic [31:0] o_data_out;
    logic [5:0]  o_length;
    logic        o_last;

    typedef struct {
        ale_pkg::t_status status;
        ale_pkg::t_slot   index;
        ale_pkg::t_word   data;
        ale_pkg::t_count  length;
        logic             last;
    } t_beat;

    // shadow copy of the list, kept in step with every accepted command
    ale_pkg::t_word list_words [ale_pkg::DEPTH];
    int    list_len;
    t_beat pending_beats [$];

    int    mismatches;
    int    burst_left;
    ale_pkg::t_word value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h8000_0000, 32'h1234_5678, 32'h7FFF_FFFF};

    array_list_engine_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_index    (o_index),
        .o_data_out (o_data_out),
        .o_length   (o_length),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // work out the beats one command yields and apply it to the shadow list
    task automatic predict_beats(input ale_pkg::t_op op, input ale_pkg::t_slot pos,
                                 input ale_pkg::t_word val);
        t_beat b;
        ale_pkg::t_word tmp;
        int    i;
        int    j;
        int    e;
        b.status = ale_pkg::ST_OK;
        b.index  = '0;
        b.data   = '0;
        b.last   = 1'b1;
        case (op)
            ale_pkg::OP_APPEND: begin
                if (list_len >= ale_pkg::DEPTH) begin
                    b.status = ale_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            ale_pkg::OP_INSERT: begin
                if (list_len >= ale_pkg::DEPTH) begin
                    b.status = ale_pkg::ST_FULL;
                end else if (int'(pos) > list_len) begin
                    b.status = ale_pkg::ST_BADPOS;
                end else begin
                    for (i = list_len; i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            ale_pkg::OP_REMOVE: begin
                if (list_len == 0) begin
                    b.status = ale_pkg::ST_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    b.status = ale_pkg::ST_BADPOS;
                end else begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            ale_pkg::OP_FIND_FIRST: begin
                b.status = ale_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_words[i] == val) begin
                        b.status = ale_pkg::ST_OK;
                        b.index  = ale_pkg::t_slot'(i);
                        break;
                    end
                end
            end
            ale_pkg::OP_FIND_LAST: begin
                b.status = ale_pkg::ST_NOTFOUND;
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_words[i] == val) begin
                        b.status = ale_pkg::ST_OK;
                        b.index  = ale_pkg::t_slot'(i);
                        break;
                    end
                end
            end
            ale_pkg::OP_SORT: begin
                for (i = 1; i < list_len; i++) begin
                    tmp = list_words[i];
                    j = i;
                    while (j > 0 && list_words[j-1] > tmp) begin
                        list_words[j] = list_words[j-1];
                        j--;
                    end
                    list_words[j] = tmp;
                end
            end
            default: begin
                if (list_len == 0) begin
                    b.status = ale_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i < list_len; i++) begin
                        e = (op == ale_pkg::OP_DUMP_FWD) ? i : list_len - 1 - i;
                        b.index  = ale_pkg::t_slot'(e);
                        b.data   = list_words[e];
                        b.length = ale_pkg::t_count'(list_len);
                        b.last   = (i == list_len - 1);
                        pending_beats.push_back(b);
                    end
                    return;
                end
            end
        endcase
        b.length = ale_pkg::t_count'(list_len);
        pending_beats.push_back(b);
    endtask

    // call just after a rising edge; returns at the edge that took the command
    task automatic send_cmd(input ale_pkg::t_op op, input ale_pkg::t_slot pos,
                            input ale_pkg::t_word val);
        start      <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_beats(op, pos, val);
    endtask

    // bursts of back-to-back commands, broken by gaps of random length
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45)
                                              : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(0, 5);
        end
    endtask

    task automatic issue(input ale_pkg::t_op op, input ale_pkg::t_slot pos,
                         input ale_pkg::t_word val);
        send_cmd(op, pos, val);
        pace();
    endtask

    function automatic ale_pkg::t_word pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    task automatic test_empty_list();
        issue(ale_pkg::OP_REMOVE,     5'd0,  32'h0);
        issue(ale_pkg::OP_FIND_FIRST, 5'd0,  32'h0);
        issue(ale_pkg::OP_FIND_LAST,  5'd31, 32'hFFFF_FFFF);
        issue(ale_pkg::OP_SORT,       5'd0,  32'h0);
        issue(ale_pkg::OP_DUMP_FWD,   5'd0,  32'h0);
        issue(ale_pkg::OP_DUMP_BWD,   5'd31, 32'h0);
        issue(ale_pkg::OP_INSERT,     5'd1,  32'hA5A5_A5A5);
    endtask

    task automatic test_edit_ops();
        issue(ale_pkg::OP_APPEND,     5'd0,  32'hFFFF_FFFF);
        issue(ale_pkg::OP_APPEND,     5'd31, 32'h0000_0000);
        issue(ale_pkg::OP_INSERT,     5'd0,  32'h0000_0005);
        // insert at the end behaves as append
        issue(ale_pkg::OP_INSERT,     5'd3,  32'hFFFF_FFFF);
        issue(ale_pkg::OP_INSERT,     5'd31, 32'h1111_1111);
        issue(ale_pkg::OP_INSERT,     5'd1,  32'h8000_0000);
        issue(ale_pkg::OP_REMOVE,     5'd31, 32'h0);
        issue(ale_pkg::OP_REMOVE,     5'd5,  32'h0);
        issue(ale_pkg::OP_FIND_FIRST, 5'd0,  32'hFFFF_FFFF);
        issue(ale_pkg::OP_FIND_LAST,  5'd0,  32'hFFFF_FFFF);
        issue(ale_pkg::OP_FIND_FIRST, 5'd0,  32'h0000_1234);
        issue(ale_pkg::OP_SORT,       5'd0,  32'h0);
        issue(ale_pkg::OP_DUMP_FWD,   5'd0,  32'h0);
        issue(ale_pkg::OP_DUMP_BWD,   5'd0,  32'h0);
        issue(ale_pkg::OP_REMOVE,     5'd0,  32'h0);
        issue(ale_pkg::OP_REMOVE,     5'd3,  32'h0);
    endtask

    task automatic test_full_list();
        while (list_len < ale_pkg::DEPTH) begin
            if ($urandom_range(0, 1) == 0)
                issue(ale_pkg::OP_APPEND, ale_pkg::t_slot'($urandom_range(0, 31)),
                      pick_value());
            else
                issue(ale_pkg::OP_INSERT, ale_pkg::t_slot'($urandom_range(0, list_len)),
                      pick_value());
        end
        issue(ale_pkg::OP_APPEND,     5'd0,  32'hDEAD_0001);
        issue(ale_pkg::OP_INSERT,     5'd31, 32'hDEAD_0002);
        issue(ale_pkg::OP_INSERT,     5'd0,  32'hDEAD_0003);
        issue(ale_pkg::OP_DUMP_FWD,   5'd0,  32'h0);
        issue(ale_pkg::OP_FIND_LAST,  5'd0,  value_pool[$urandom_range(0, 5)]);
        issue(ale_pkg::OP_SORT,       5'd0,  32'h0);
        issue(ale_pkg::OP_DUMP_BWD,   5'd0,  32'h0);
        issue(ale_pkg::OP_FIND_FIRST, 5'd0,  value_pool[$urandom_range(0, 5)]);
        issue(ale_pkg::OP_REMOVE,     5'd31, 32'h0);
        while (list_len > 10)
            issue(ale_pkg::OP_REMOVE, ale_pkg::t_slot'($urandom_range(0, list_len - 1)),
                  32'h0);
    endtask

    task automatic test_random_ops();
        ale_pkg::t_op   op;
        ale_pkg::t_slot pos;
        int    roll;
        repeat (20) begin
            roll = $urandom_range(0, 99);
            // lean towards growing a short list and shrinking a long one
            if (list_len < 4)
                roll = (roll < 60) ? roll % 40 : roll;
            else if (list_len > 28)
                roll = (roll < 50) ? 40 + roll % 15 : roll;
            if (roll < 20)      op = ale_pkg::OP_APPEND;
            else if (roll < 40) op = ale_pkg::OP_INSERT;
            else if (roll < 55) op = ale_pkg::OP_REMOVE;
            else if (roll < 67) op = ale_pkg::OP_FIND_FIRST;
            else if (roll < 79) op = ale_pkg::OP_FIND_LAST;
            else if (roll < 87) op = ale_pkg::OP_SORT;
            else if (roll < 94) op = ale_pkg::OP_DUMP_FWD;
            else                op = ale_pkg::OP_DUMP_BWD;
            if ($urandom_range(0, 4) == 0)
                pos = ale_pkg::t_slot'($urandom_range(0, 31));
            else if (op == ale_pkg::OP_REMOVE && list_len > 0)
                pos = ale_pkg::t_slot'($urandom_range(0, list_len - 1));
            else
                pos = ale_pkg::t_slot'($urandom_range(0, (list_len > 31) ? 31 : list_len));
            issue(op, pos, pick_value());
        end
    endtask

    // every beat is on the ports for one cycle only: take it at each edge
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d index %0d data %h length %0d last %b",
                             o_status, o_index, o_data_out, o_length, o_last);
            end else begin
                want = pending_beats.pop_front();
                if (o_status !== want.status || o_index !== want.index ||
                    o_data_out !== want.data || o_length !== want.length ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected status %0d index %0d data %h length %0d last %b",
                                 want.status, want.index, want.data, want.length, want.last);
                        $display("          got status %0d index %0d data %h length %0d last %b",
                                 o_status, o_index, o_data_out, o_length, o_last);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_opcode   <= ale_pkg::OP_APPEND;
        i_position <= '0;
        i_value    <= '0;
        list_len   = 0;
        mismatches = 0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edit_ops();
        test_full_list();
        test_random_ops();

        start <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/array_list_engine_unit.sv
verif/tb_array_list_engine_unit.sv
